FILE: hw/rtl/smao_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smao_pkg
// Shared constants, codes and controller/datapath types for the sensor
// moving average and overcurrent core.
// ----------------------------------------------------------------------------
package smao_pkg;

  localparam int MAX_WINDOW   = 8;
  localparam int NUM_CHANNELS = 6;

  localparam int CH_W   = 3;
  localparam int SMP_W  = 10;
  localparam int WL_W   = 4;
  localparam int LIM_W  = 9;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT = CFG_IDX_W'(1);

  localparam logic [WL_W-1:0]  WINDOW_RESET = WL_W'(4);
  localparam logic [LIM_W-1:0] LIMIT_RESET  = LIM_W'(511);
  localparam logic [SMP_W-1:0] MIDSCALE     = SMP_W'(512);

  localparam int CUR_CH_A = 2;
  localparam int CUR_CH_B = 3;

  localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int HIST_DEPTH = NUM_CHANNELS * MAX_WINDOW;
  localparam int ADDR_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int SUM_W      = $clog2(MAX_WINDOW * ((1 << SMP_W) - 1) + 1);
  localparam int DCNT_W     = $clog2(SUM_W + 1);

  typedef struct packed {
    logic accept;
    logic load;
    logic rd;
    logic div_init;
    logic div_step;
    logic store;
    logic load_out;
  } smao_cmd_t;

  typedef struct packed {
    logic in_range;
    logic taps_left;
    logic rd_pend;
    logic div_last;
    logic out_free;
  } smao_status_t;

endpackage
`default_nettype wire

FILE: hw/rtl/smao_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smao_ifs
// Sample request, result request and configuration write channels.
// ----------------------------------------------------------------------------
interface smao_in_if;
  import smao_pkg::*;
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   channel;
  logic [SMP_W-1:0]  sample;
  modport source (output valid, channel, sample, input ready);
  modport sink   (input valid, channel, sample, output ready);
endinterface

interface smao_out_if;
  import smao_pkg::*;
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   channel_out;
  logic [SMP_W-1:0]  average;
  logic              overcurrent;
  modport source (output valid, channel_out, average, overcurrent, input ready);
  modport sink   (input valid, channel_out, average, overcurrent, output ready);
endinterface

interface smao_cfg_if;
  import smao_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/smao_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smao_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module smao_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/smao_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smao_ctrl
// Sequencer: accept, history write, window sum, serial divide, store, output.
// ----------------------------------------------------------------------------
module smao_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire smao_pkg::smao_status_t st,
  output smao_pkg::smao_cmd_t         cmd
);
  import smao_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SUM,
    S_DIV,
    S_STORE,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.accept = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (st.in_range) begin
          cmd.load   = 1'b1;
          state_next = S_SUM;
        end else begin
          state_next = S_OUT;
        end
      end
      S_SUM: begin
        cmd.rd = st.taps_left;
        if (!st.taps_left && !st.rd_pend) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/smao_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smao_dp
// Datapath: configuration, per-channel history pointers and fill counts,
// history RAM, window accumulator, restoring divider, means and output stage.
// ----------------------------------------------------------------------------
module smao_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire smao_pkg::smao_cmd_t              cmd,
  output smao_pkg::smao_status_t                st,
  input  wire logic [smao_pkg::CH_W-1:0]        in_channel,
  input  wire logic [smao_pkg::SMP_W-1:0]       in_sample,
  input  wire logic                             cfg_valid,
  input  wire logic [smao_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [smao_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [smao_pkg::CH_W-1:0]        out_channel,
  output logic      [smao_pkg::SMP_W-1:0]       out_average,
  output logic                                  out_overcurrent
);
  import smao_pkg::*;

  logic [WL_W-1:0]   window_length;
  logic [LIM_W-1:0]  current_limit;

  logic [SLOT_W-1:0] wptr  [NUM_CHANNELS];
  logic [WIN_W-1:0]  cnt   [NUM_CHANNELS];
  logic [SMP_W-1:0]  means [NUM_CHANNELS];

  logic [CH_W-1:0]   ch_q;
  logic [SMP_W-1:0]  smp_q;
  logic [SLOT_W-1:0] ptr_q;
  logic [WIN_W-1:0]  cnt_q;
  logic [SLOT_W-1:0] slot_q;
  logic [WIN_W-1:0]  ncnt_q;
  logic [WIN_W-1:0]  k_q;
  logic              rd_pend_q;
  logic              tap_ok_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]  quo_q;
  logic [WIN_W-1:0]  rem_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [SMP_W-1:0]  avg_q;

  logic [WIN_W-1:0]  w_eff;
  logic [SLOT_W-1:0] ptr_sel;
  logic [WIN_W-1:0]  cnt_sel;
  logic [SLOT_W-1:0] p_next;
  logic [WIN_W-1:0]  ncnt;
  logic [SLOT_W-1:0] tap_slot;
  logic [SLOT_W-1:0] slot_sel;
  logic [ADDR_W-1:0] ram_addr;
  logic [SMP_W-1:0]  ram_rdata;
  logic [WIN_W:0]    trial;
  logic              ge;
  logic [SMP_W-1:0]  mean_a;
  logic [SMP_W-1:0]  mean_b;
  logic              oc;

  function automatic logic outside_band(input logic [SMP_W-1:0] m,
                                        input logic [LIM_W-1:0] lim);
    logic [SMP_W:0] mw;
    logic [SMP_W:0] hi;
    logic [SMP_W:0] lo;
    mw = {1'b0, m};
    hi = {1'b0, MIDSCALE} + (SMP_W + 1)'(lim);
    lo = mw + (SMP_W + 1)'(lim);
    return (mw > hi) || (lo < {1'b0, MIDSCALE});
  endfunction

  always_comb begin
    if (window_length == '0) begin
      w_eff = WIN_W'(1);
    end else if (int'(window_length) > MAX_WINDOW) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end else begin
      w_eff = WIN_W'(window_length);
    end
  end

  always_comb begin
    ptr_sel = '0;
    cnt_sel = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (in_channel == CH_W'(i)) begin
        ptr_sel = wptr[i];
        cnt_sel = cnt[i];
      end
    end
  end

  always_comb begin
    if (int'(ptr_q) >= MAX_WINDOW - 1) begin
      p_next = '0;
    end else begin
      p_next = ptr_q + SLOT_W'(1);
    end
    if (int'(cnt_q) >= MAX_WINDOW) begin
      ncnt = cnt_q;
    end else begin
      ncnt = cnt_q + WIN_W'(1);
    end
  end

  always_comb begin
    int t;
    t = int'(slot_q) - int'(k_q);
    if (t < 0) begin
      t = t + MAX_WINDOW;
    end
    tap_slot = SLOT_W'(t);
  end

  assign slot_sel = cmd.load ? p_next : tap_slot;
  assign ram_addr = ADDR_W'(int'(ch_q) * MAX_WINDOW + int'(slot_sel));

  smao_ram #(
    .WIDTH (SMP_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.load),
    .addr  (ram_addr),
    .wdata (smp_q),
    .rdata (ram_rdata)
  );

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign ge    = trial >= {1'b0, w_eff};

  always_comb begin
    mean_a = MIDSCALE;
    mean_b = MIDSCALE;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (i == CUR_CH_A) begin
        mean_a = means[i];
      end
      if (i == CUR_CH_B) begin
        mean_b = means[i];
      end
    end
  end

  assign oc = outside_band(mean_a, current_limit) || outside_band(mean_b, current_limit);

  assign st.in_range  = int'(ch_q) < NUM_CHANNELS;
  assign st.taps_left = k_q < w_eff;
  assign st.rd_pend   = rd_pend_q;
  assign st.div_last  = dcnt_q == DCNT_W'(SUM_W - 1);
  assign st.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
      current_limit <= LIMIT_RESET;
      rd_pend_q     <= 1'b0;
      out_valid     <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        wptr[i]  <= '0;
        cnt[i]   <= '0;
        means[i] <= MIDSCALE;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_WINDOW_LENGTH: window_length <= cfg_data[WL_W-1:0];
          REG_CURRENT_LIMIT: current_limit <= cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end

      if (cmd.accept) begin
        ch_q  <= in_channel;
        smp_q <= in_sample;
        ptr_q <= ptr_sel;
        cnt_q <= cnt_sel;
        avg_q <= '0;
      end

      if (cmd.load) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (ch_q == CH_W'(i)) begin
            wptr[i] <= p_next;
            cnt[i]  <= ncnt;
          end
        end
        slot_q <= p_next;
        ncnt_q <= ncnt;
        sum_q  <= SUM_W'(smp_q);
        k_q    <= WIN_W'(1);
      end

      rd_pend_q <= cmd.rd;
      if (cmd.rd) begin
        tap_ok_q <= k_q < ncnt_q;
        k_q      <= k_q + WIN_W'(1);
      end

      if (rd_pend_q && tap_ok_q) begin
        sum_q <= sum_q + SUM_W'(ram_rdata);
      end

      if (cmd.div_init) begin
        quo_q  <= sum_q;
        rem_q  <= '0;
        dcnt_q <= '0;
      end

      if (cmd.div_step) begin
        quo_q  <= {quo_q[SUM_W-2:0], ge};
        rem_q  <= ge ? WIN_W'(trial - {1'b0, w_eff}) : WIN_W'(trial);
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end

      if (cmd.store) begin
        avg_q <= quo_q[SMP_W-1:0];
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (ch_q == CH_W'(i)) begin
            means[i] <= quo_q[SMP_W-1:0];
          end
        end
      end

      if (cmd.load_out) begin
        out_valid       <= 1'b1;
        out_channel     <= ch_q;
        out_average     <= avg_q;
        out_overcurrent <= oc;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sensor_moving_average_overcurrent_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_moving_average_overcurrent_core
// Six-channel moving average with window comparator on the current channels.
// ----------------------------------------------------------------------------
// Each accepted sample request yields one result: the echoed channel, the
// truncated mean of the newest w samples, w being window_length clamped to
// 1 to 8, and the overcurrent flag for the means of channels 2 and 3. A
// request for a valid channel first enters its channel's history; the
// controller then does one history RAM read per older window tap and runs
// the restoring divider, which forms one quotient bit per cycle over the
// 13-bit window sum. A channel number beyond the last channel skips the
// history and the divider and yields a zero average. One request is in work
// at a time; the next is taken while a finished result waits in the output
// register. Per-channel fill counts make untouched history read as zero
// after reset, so there is no clearing pass. Configuration writes are taken
// in any cycle out of reset and must be issued only while the block is idle.
module sensor_moving_average_overcurrent_core (
  input  wire logic clk,
  input  wire logic rst,
  smao_in_if.sink   samples,
  smao_out_if.source results,
  smao_cfg_if.sink  cfg
);
  import smao_pkg::*;

  smao_cmd_t    cmd;
  smao_status_t st;

  assign cfg.ready = !rst;

  smao_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .st       (st),
    .cmd      (cmd)
  );

  smao_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .in_channel      (samples.channel),
    .in_sample       (samples.sample),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .out_channel     (results.channel_out),
    .out_average     (results.average),
    .out_overcurrent (results.overcurrent)
  );

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the six-channel moving average core. Sample
// requests are sent in random bursts while the result side stalls on its own
// pattern; every result is compared field by field with a behavioral model of
// the per-channel history, the windowed mean and the overcurrent band check.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import smao_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
  localparam int SMP_MAX       = (1 << SMP_W) - 1;
  localparam int CH_MAX        = (1 << CH_W) - 1;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_REPORTS   = 40;
  localparam int PHASE_ITEMS   = 150;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] average;
    logic             overcurrent;
  } mean_result_t;

  logic clk = 1'b0;
  logic rst;

  smao_in_if  sample_bus ();
  smao_out_if result_bus ();
  smao_cfg_if cfg_bus ();

  sensor_moving_average_overcurrent_core dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_bus),
    .results (result_bus),
    .cfg     (cfg_bus)
  );

  logic [SMP_W-1:0] sample_hist [NUM_CHANNELS][MAX_WINDOW];
  logic [SMP_W-1:0] mean_store [NUM_CHANNELS];
  logic [WL_W-1:0]  window_reg;
  logic [LIM_W-1:0] limit_reg;
  mean_result_t     expected_means [$];
  int               error_count = 0;
  int               cycle_count = 0;
  int               hold_left = 0;
  bit               stall_enable = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic bit out_of_band(logic [SMP_W-1:0] m);
    return (int'(m) > int'(MIDSCALE) + int'(limit_reg)) ||
           (int'(m) + int'(limit_reg) < int'(MIDSCALE));
  endfunction

  function automatic mean_result_t predict_mean(logic [CH_W-1:0] ch, logic [SMP_W-1:0] smp);
    mean_result_t r;
    int w;
    int sum;
    r.channel = ch;
    r.average = '0;
    if (ch < NUM_CHANNELS) begin
      w = (window_reg == 0) ? 1 : (window_reg > MAX_WINDOW) ? MAX_WINDOW : int'(window_reg);
      for (int k = MAX_WINDOW - 1; k > 0; k--) sample_hist[ch][k] = sample_hist[ch][k-1];
      sample_hist[ch][0] = smp;
      sum = 0;
      for (int k = 0; k < w; k++) sum += int'(sample_hist[ch][k]);
      r.average = SMP_W'(sum / w);
      mean_store[ch] = r.average;
    end
    r.overcurrent = out_of_band(mean_store[CUR_CH_A]) || out_of_band(mean_store[CUR_CH_B]);
    return r;
  endfunction

  task automatic report_error(string msg);
    if (error_count < MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic send_sample(logic [CH_W-1:0] ch, logic [SMP_W-1:0] smp);
    sample_bus.valid   <= 1'b1;
    sample_bus.channel <= ch;
    sample_bus.sample  <= smp;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    expected_means.push_back(predict_mean(ch, smp));
  endtask

  task automatic pause_sender(int cycles);
    sample_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    sample_bus.valid <= 1'b0;
    do @(posedge clk); while (expected_means.size() != 0);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == REG_WINDOW_LENGTH) window_reg = value[WL_W-1:0];
    else if (idx == REG_CURRENT_LIMIT) limit_reg = value[LIM_W-1:0];
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] win, logic [CFG_DATA_W-1:0] lim);
    write_register(REG_WINDOW_LENGTH, win);
    write_register(REG_CURRENT_LIMIT, lim);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [CH_W-1:0] pick_channel();
    if ($urandom_range(0, 11) == 0) return CH_W'($urandom_range(NUM_CHANNELS, CH_MAX));
    if ($urandom_range(0, 2) == 0) return CH_W'($urandom_range(CUR_CH_A, CUR_CH_B));
    return CH_W'($urandom_range(0, NUM_CHANNELS - 1));
  endfunction

  function automatic logic [SMP_W-1:0] pick_sample(logic [CH_W-1:0] ch);
    int pick;
    int edge_val;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick < 5 || (ch != CUR_CH_A && ch != CUR_CH_B)) return SMP_W'($urandom);
    // aim at the band boundary of the current comparator
    edge_val = int'(MIDSCALE) + (($urandom_range(0, 1) == 1) ? int'(limit_reg) : -int'(limit_reg));
    edge_val += int'($urandom_range(0, 6)) - 3;
    if (edge_val < 0) edge_val = 0;
    if (edge_val > SMP_MAX) edge_val = SMP_MAX;
    return SMP_W'(edge_val);
  endfunction

  initial begin : result_sink
    logic [7:0] stall_mask;
    int slot;
    stall_mask = '1;
    slot = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (slot == 0) stall_mask = 8'($urandom | $urandom);
      slot = (slot + 1) % 8;
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (stall_enable) begin
        result_bus.ready <= stall_mask[slot];
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    mean_result_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_means.size() == 0) begin
        report_error($sformatf("result for channel %0d with none pending",
                               result_bus.channel_out));
      end else begin
        want = expected_means.pop_front();
        if (result_bus.channel_out !== want.channel)
          report_error($sformatf("channel_out %0d, expected %0d",
                                 result_bus.channel_out, want.channel));
        if (result_bus.average !== want.average)
          report_error($sformatf("average %0d, expected %0d (channel %0d)",
                                 result_bus.average, want.average, want.channel));
        if (result_bus.overcurrent !== want.overcurrent)
          report_error($sformatf("overcurrent %b, expected %b (channel %0d)",
                                 result_bus.overcurrent, want.overcurrent, want.channel));
      end
    end
  end

  task automatic test_reset_defaults();
    send_sample(CH_W'(0), SMP_W'(SMP_MAX));
    send_sample(CH_W'(0), SMP_W'(SMP_MAX));
    pause_sender(3);
    send_sample(CH_W'(0), SMP_W'(SMP_MAX));
    send_sample(CH_W'(0), SMP_W'(SMP_MAX));
    send_sample(CH_W'(1), SMP_W'(0));
    send_sample(CH_W'(CUR_CH_A), SMP_W'(0));
    send_sample(CH_W'(CUR_CH_B), SMP_W'(SMP_MAX));
    pause_sender(1);
    send_sample(CH_W'(NUM_CHANNELS), SMP_W'(345));
    send_sample(CH_W'(CH_MAX), SMP_W'(SMP_MAX));
    send_sample(CH_W'(4), MIDSCALE);
    send_sample(CH_W'(5), SMP_W'(1));
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_register(REG_SPARE, '1);
    configure(CFG_DATA_W'(0), CFG_DATA_W'(0));
    send_sample(CH_W'(CUR_CH_B), MIDSCALE);
    send_sample(CH_W'(CUR_CH_A), MIDSCALE);
    send_sample(CH_W'(CUR_CH_A), MIDSCALE + SMP_W'(1));
    send_sample(CH_W'(CUR_CH_A), MIDSCALE - SMP_W'(1));
    send_sample(CH_W'(CUR_CH_A), MIDSCALE);
    wait_drained();
    configure(CFG_DATA_W'(15), CFG_DATA_W'(LIMIT_RESET));
    send_sample(CH_W'(0), SMP_W'(SMP_MAX));
    send_sample(CH_W'(5), SMP_W'(0));
    wait_drained();
    // upper data bits must not leak into the window register
    configure(CFG_DATA_W'('h1F8), CFG_DATA_W'(256));
    send_sample(CH_W'(1), SMP_W'(SMP_MAX));
    send_sample(CH_W'(CUR_CH_B), SMP_W'(255));
    send_sample(CH_W'(4), SMP_W'('h2AA));
    wait_drained();
  endtask

  task automatic test_output_hold_off();
    logic [CH_W-1:0] ch;
    stall_enable = 1'b0;
    hold_left = LONG_HOLD;
    repeat (16) begin
      ch = pick_channel();
      send_sample(ch, pick_sample(ch));
    end
    wait_drained();
  endtask

  task automatic run_random_phase(logic [CFG_DATA_W-1:0] win, logic [CFG_DATA_W-1:0] lim,
                                  bit stalls);
    logic [CH_W-1:0] ch;
    int sent;
    int burst;
    bit drained;
    wait_drained();
    configure(win, lim);
    stall_enable = stalls;
    sent = 0;
    drained = 1'b0;
    while (sent < PHASE_ITEMS) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        ch = pick_channel();
        send_sample(ch, pick_sample(ch));
        sent++;
      end
      if (!drained && sent >= PHASE_ITEMS / 2) begin
        wait_drained();
        drained = 1'b1;
      end else if ($urandom_range(0, 2) != 0) begin
        pause_sender($urandom_range(1, 40));
      end
    end
  endtask

  task automatic test_random_phases();
    run_random_phase(CFG_DATA_W'(MAX_WINDOW), CFG_DATA_W'(LIMIT_RESET), 1'b0);
    run_random_phase(CFG_DATA_W'(1), CFG_DATA_W'(0), 1'b1);
    run_random_phase(CFG_DATA_W'(15), CFG_DATA_W'($urandom), 1'b1);
    run_random_phase(CFG_DATA_W'(0), CFG_DATA_W'($urandom_range(1, 20)), 1'b1);
    run_random_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, 511)), 1'b1);
    run_random_phase(CFG_DATA_W'($urandom_range(2, 7)), CFG_DATA_W'(255), 1'b0);
  endtask

  initial begin
    rst                <= 1'b1;
    sample_bus.valid   <= 1'b0;
    sample_bus.channel <= '0;
    sample_bus.sample  <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= '0;
    cfg_bus.data       <= '0;
    window_reg = WINDOW_RESET;
    limit_reg  = LIMIT_RESET;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      mean_store[c] = MIDSCALE;
      for (int k = 0; k < MAX_WINDOW; k++) sample_hist[c][k] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_output_hold_off();
    test_random_phases();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_means.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/smao_pkg.sv
hw/rtl/smao_ifs.sv
hw/rtl/smao_ram.sv
hw/rtl/smao_ctrl.sv
hw/rtl/smao_dp.sv
hw/rtl/sensor_moving_average_overcurrent_core.sv
tb/sv/testbench.sv
